@@ rtl/rbwc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbwc_pkg
// Shared types and constants for the repeated box window clipper.
// ----------------------------------------------------------------------------
package rbwc_pkg;

   localparam int REP_LIMIT_DEFAULT = 8;

   localparam int COORD_W = 24;
   localparam int EDGE_W  = 25;
   localparam int STEP_W  = 20;
   localparam int COUNT_W = 3;
   localparam int LAYER_W = 6;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_WIN_LEFT   = 3'd0,
      CSR_WIN_RIGHT  = 3'd1,
      CSR_WIN_BOTTOM = 3'd2,
      CSR_WIN_TOP    = 3'd3,
      CSR_VISIBLE    = 3'd4,
      CSR_CHECK_MODE = 3'd5
   } csr_index_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic load_item;
      logic next_col;
      logic next_row;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic visible;
      logic col_last;
      logic row_last;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/repeated_box_window_clipper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// repeated_box_window_clipper
// Expands an arrayed box into its copies and tests and clips each against
// a window.
// ----------------------------------------------------------------------------
// One item is accepted while the block is idle. It then gives one result per
// cycle while results are taken, rows outer and columns inner, for
// (extra_cols+1)*(extra_rows+1) results; the copy stepper adds the step to
// the held edges for each copy. With display disabled an item gives one
// empty result marked last. rsp_tuser carries the hit flag. Window and mode
// registers are written over the APB port; the user must write them only
// while no item is in flight, which the block itself does not enforce.
module repeated_box_window_clipper #(
   parameter int REP_LIMIT = rbwc_pkg::REP_LIMIT_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [rbwc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [rbwc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rbwc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // layer, base_left, base_right, base_bottom, base_top, extra_cols,
   // extra_rows, step_x, step_y, zero pad
   input  wire  [rbwc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // out_layer, box_left, box_right, box_bottom, box_top, col_index, row_index
   output logic [rbwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // hit
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   rbwc_pkg::cmd_type  cmd;
   rbwc_pkg::stat_type stat;

   rbwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rbwc_datapath #(
      .REP_LIMIT (REP_LIMIT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tdata   (req_tdata),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
`default_nettype wire

@@ rtl/rbwc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbwc_ctrl
// Sequencer: takes one item, then steps through its copies one per cycle
// while the result register is free.
// ----------------------------------------------------------------------------
module rbwc_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  rbwc_pkg::stat_type  stat,
   output rbwc_pkg::cmd_type   cmd
);

   rbwc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbwc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rbwc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = rbwc_pkg::ST_RUN;
            end
         end
         rbwc_pkg::ST_RUN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               if (!stat.visible || (stat.col_last && stat.row_last)) begin
                  state_in = rbwc_pkg::ST_IDLE;
               end else if (stat.col_last) begin
                  cmd.next_row = 1'b1;
               end else begin
                  cmd.next_col = 1'b1;
               end
            end
         end
         default: state_in = rbwc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/rbwc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbwc_datapath
// Window registers, held item, copy stepper, overlap test, clipping and
// result register.
// ----------------------------------------------------------------------------
module rbwc_datapath #(
   parameter int REP_LIMIT = rbwc_pkg::REP_LIMIT_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [rbwc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [rbwc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rbwc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   input  wire  [rbwc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [rbwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  rbwc_pkg::cmd_type                   cmd,
   output rbwc_pkg::stat_type                  stat
);

   localparam int CW = rbwc_pkg::COORD_W;
   localparam int EW = rbwc_pkg::EDGE_W;
   localparam int SW = rbwc_pkg::STEP_W;
   localparam int NW = rbwc_pkg::COUNT_W;
   localparam int LW = rbwc_pkg::LAYER_W;
   localparam logic [NW-1:0] MAX_COUNT = NW'(REP_LIMIT - 1);

   // window and mode registers
   logic signed [CW-1:0] win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;
   logic                 visible_ff, check_mode_ff;
   logic                 csr_write;
   rbwc_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = rbwc_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_right_ff  <= '0;
         win_bottom_ff <= '0;
         win_top_ff    <= '0;
         visible_ff    <= 1'b1;
         check_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            rbwc_pkg::CSR_WIN_LEFT:   win_left_ff   <= csr_pwdata[CW-1:0];
            rbwc_pkg::CSR_WIN_RIGHT:  win_right_ff  <= csr_pwdata[CW-1:0];
            rbwc_pkg::CSR_WIN_BOTTOM: win_bottom_ff <= csr_pwdata[CW-1:0];
            rbwc_pkg::CSR_WIN_TOP:    win_top_ff    <= csr_pwdata[CW-1:0];
            rbwc_pkg::CSR_VISIBLE:    visible_ff    <= csr_pwdata[0];
            rbwc_pkg::CSR_CHECK_MODE: check_mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         rbwc_pkg::CSR_WIN_LEFT:   csr_prdata[CW-1:0] = win_left_ff;
         rbwc_pkg::CSR_WIN_RIGHT:  csr_prdata[CW-1:0] = win_right_ff;
         rbwc_pkg::CSR_WIN_BOTTOM: csr_prdata[CW-1:0] = win_bottom_ff;
         rbwc_pkg::CSR_WIN_TOP:    csr_prdata[CW-1:0] = win_top_ff;
         rbwc_pkg::CSR_VISIBLE:    csr_prdata[0]      = visible_ff;
         rbwc_pkg::CSR_CHECK_MODE: csr_prdata[0]      = check_mode_ff;
         default:                  csr_prdata         = '0;
      endcase
   end

   // request fields
   logic [LW-1:0]        in_layer;
   logic signed [CW-1:0] in_left, in_right, in_bottom, in_top;
   logic [NW-1:0]        in_cols, in_rows;
   logic signed [SW-1:0] in_step_x, in_step_y;

   assign in_layer  = req_tdata[5:0];
   assign in_left   = req_tdata[29:6];
   assign in_right  = req_tdata[53:30];
   assign in_bottom = req_tdata[77:54];
   assign in_top    = req_tdata[101:78];
   assign in_cols   = req_tdata[104:102];
   assign in_rows   = req_tdata[107:105];
   assign in_step_x = req_tdata[127:108];
   assign in_step_y = req_tdata[147:128];

   // held item and copy stepper
   logic [LW-1:0]        layer_ff;
   logic [NW-1:0]        cols_ff, rows_ff;
   logic signed [SW-1:0] step_x_ff, step_y_ff;
   logic signed [CW-1:0] base_left_ff, base_right_ff;
   logic signed [EW-1:0] cur_left_ff, cur_right_ff, cur_bottom_ff, cur_top_ff;
   logic [NW-1:0]        col_ff, row_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         layer_ff      <= in_layer;
         cols_ff       <= (in_cols > MAX_COUNT) ? MAX_COUNT : in_cols;
         rows_ff       <= (in_rows > MAX_COUNT) ? MAX_COUNT : in_rows;
         step_x_ff     <= in_step_x;
         step_y_ff     <= in_step_y;
         base_left_ff  <= in_left;
         base_right_ff <= in_right;
         cur_left_ff   <= EW'(in_left);
         cur_right_ff  <= EW'(in_right);
         cur_bottom_ff <= EW'(in_bottom);
         cur_top_ff    <= EW'(in_top);
      end else if (cmd.next_col) begin
         cur_left_ff  <= cur_left_ff + EW'(step_x_ff);
         cur_right_ff <= cur_right_ff + EW'(step_x_ff);
      end else if (cmd.next_row) begin
         cur_left_ff   <= EW'(base_left_ff);
         cur_right_ff  <= EW'(base_right_ff);
         cur_bottom_ff <= cur_bottom_ff + EW'(step_y_ff);
         cur_top_ff    <= cur_top_ff + EW'(step_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load_item) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.next_col) begin
         col_ff <= col_ff + NW'(1);
      end else if (cmd.next_row) begin
         col_ff <= '0;
         row_ff <= row_ff + NW'(1);
      end
   end

   assign stat.visible  = visible_ff;
   assign stat.col_last = (col_ff == cols_ff);
   assign stat.row_last = (row_ff == rows_ff);

   // overlap test and clipping
   logic signed [EW-1:0] wl, wr, wb, wt;
   logic signed [EW-1:0] clip_left, clip_right, clip_bottom, clip_top;
   logic                 hit;

   assign wl = EW'(win_left_ff);
   assign wr = EW'(win_right_ff);
   assign wb = EW'(win_bottom_ff);
   assign wt = EW'(win_top_ff);

   assign hit = (cur_left_ff < wr) && (cur_right_ff > wl) &&
                (cur_bottom_ff < wt) && (cur_top_ff > wb);

   always_comb begin
      clip_left   = cur_left_ff;
      clip_right  = cur_right_ff;
      clip_bottom = cur_bottom_ff;
      clip_top    = cur_top_ff;
      if (!check_mode_ff) begin
         if (wl > cur_left_ff)   clip_left   = wl;
         if (wr < cur_right_ff)  clip_right  = wr;
         if (wb > cur_bottom_ff) clip_bottom = wb;
         if (wt < cur_top_ff)    clip_top    = wt;
      end
   end

   // result register
   logic [LW-1:0]        out_layer_ff;
   logic                 hit_ff, last_ff;
   logic signed [EW-1:0] box_left_ff, box_right_ff, box_bottom_ff, box_top_ff;
   logic [NW-1:0]        col_index_ff, row_index_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_layer_ff <= layer_ff;
         if (visible_ff) begin
            hit_ff        <= hit;
            box_left_ff   <= clip_left;
            box_right_ff  <= clip_right;
            box_bottom_ff <= clip_bottom;
            box_top_ff    <= clip_top;
            col_index_ff  <= col_ff;
            row_index_ff  <= row_ff;
            last_ff       <= stat.col_last & stat.row_last;
         end else begin
            hit_ff        <= 1'b0;
            box_left_ff   <= '0;
            box_right_ff  <= '0;
            box_bottom_ff <= '0;
            box_top_ff    <= '0;
            col_index_ff  <= '0;
            row_index_ff  <= '0;
            last_ff       <= 1'b1;
         end
      end
   end

   assign rsp_tdata = {row_index_ff, col_index_ff, box_top_ff, box_bottom_ff,
                       box_right_ff, box_left_ff, out_layer_ff};
   assign rsp_tuser = hit_ff;
   assign rsp_tlast = last_ff;

endmodule
`default_nettype wire

@@ rtl/rbwc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbwc_checker
// Port-level checks for the repeated box window clipper.
// ----------------------------------------------------------------------------
module rbwc_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [rbwc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire                              rsp_tuser,
   input wire                              rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no new item right after one is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while previous item in progress");

   // no new item while an item still has results to come
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("item taken before last result");

   // nothing offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind repeated_box_window_clipper rbwc_checker u_rbwc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

@@ verif/tb_repeated_box_window_clipper.sv @@
// ----------------------------------------------------------------------------
// tb_repeated_box_window_clipper
// Self-checking bench for the repeated box window clipper. Arrayed boxes go
// in over the request stream, and every copy that comes back is compared
// field by field with a copy expanded and clipped here against the window
// last written over APB. A directed table with extremes and edge cases runs
// first, then randomized phases with fresh window and mode settings and, in
// most phases, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_repeated_box_window_clipper;

   localparam int          MAX_IDLE     = 18;
   localparam int          RAND_PHASES  = 8;
   localparam int          PHASE_ITEMS  = 24;
   localparam int          DRAIN_CYCLES = 80;
   localparam int          CYCLE_LIMIT  = 1500000;
   localparam logic [2:0]  KEEP_WIN     = 3'd7;

   localparam int LAYER_W    = rbwc_pkg::LAYER_W;
   localparam int COORD_W    = rbwc_pkg::COORD_W;
   localparam int EDGE_W     = rbwc_pkg::EDGE_W;
   localparam int STEP_W     = rbwc_pkg::STEP_W;
   localparam int COUNT_W    = rbwc_pkg::COUNT_W;
   localparam int REQ_DATA_W = rbwc_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = rbwc_pkg::RSP_DATA_W;
   localparam int CSR_ADDR_W = rbwc_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = rbwc_pkg::CSR_DATA_W;

   typedef struct packed {
      logic [LAYER_W-1:0]        layer;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
      logic signed [COORD_W-1:0] top;
      logic [COUNT_W-1:0]        cols;
      logic [COUNT_W-1:0]        rows;
      logic signed [STEP_W-1:0]  step_x;
      logic signed [STEP_W-1:0]  step_y;
   } box_item_type;

   typedef struct packed {
      logic [LAYER_W-1:0]       layer;
      logic                     hit;
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] right;
      logic signed [EDGE_W-1:0] bottom;
      logic signed [EDGE_W-1:0] top;
      logic [COUNT_W-1:0]       col;
      logic [COUNT_W-1:0]       row;
      logic                     last;
   } box_copy_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
      logic signed [COORD_W-1:0] top;
      logic                      visible;
      logic                      check;
   } window_type;

   typedef struct packed {
      logic [2:0]   win_sel;
      box_item_type item;
      logic         typed;
      box_copy_type golden;
   } dir_row_type;

   localparam window_type DIR_WINDOWS [6] = '{
      '{-24'sd100, 24'sd100, -24'sd100, 24'sd100, 1'b1, 1'b0},
      '{-24'sd100, 24'sd100, -24'sd100, 24'sd100, 1'b1, 1'b1},
      '{-24'sd100, 24'sd100, -24'sd100, 24'sd100, 1'b0, 1'b0},
      '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1, 1'b0},
      '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1, 1'b0},
      '{24'sd100, -24'sd100, 24'sd50, -24'sd50, 1'b1, 1'b1}
   };

   localparam dir_row_type DIRECTED_ROWS [20] = '{
      // reset window is a point at the origin
      '{KEEP_WIN,
        '{6'd63, -24'sd5, 24'sd5, -24'sd5, 24'sd5, 3'd0, 3'd0, 20'sd0, 20'sd0}, 1'b1,
        '{6'd63, 1'b1, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd62, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 3'd7, 3'd7,
          20'sh7FFFF, 20'sh7FFFF}, 1'b0, '0},
      '{KEEP_WIN,
        '{6'd0, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 3'd7, 3'd7,
          20'sh80000, 20'sh80000}, 1'b0, '0},
      // inside, touching, outside and swapped edges
      '{3'd0,
        '{6'd1, -24'sd10, 24'sd10, -24'sd10, 24'sd10, 3'd0, 3'd0, 20'sd0, 20'sd0}, 1'b1,
        '{6'd1, 1'b1, -25'sd10, 25'sd10, -25'sd10, 25'sd10, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd2, 24'sd100, 24'sd200, -24'sd10, 24'sd10, 3'd0, 3'd0, 20'sd0, 20'sd0}, 1'b1,
        '{6'd2, 1'b0, 25'sd100, 25'sd100, -25'sd10, 25'sd10, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd3, -24'sd10, 24'sd10, 24'sd100, 24'sd300, 3'd0, 3'd0, 20'sd0, 20'sd0}, 1'b1,
        '{6'd3, 1'b0, -25'sd10, 25'sd10, 25'sd100, 25'sd100, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd4, 24'sd500, 24'sd600, -24'sd10, 24'sd10, 3'd0, 3'd0, 20'sd0, 20'sd0}, 1'b1,
        '{6'd4, 1'b0, 25'sd500, 25'sd100, -25'sd10, 25'sd10, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd5, 24'sd50, -24'sd50, -24'sd10, 24'sd10, 3'd0, 3'd0, 20'sd0, 20'sd0}, 1'b1,
        '{6'd5, 1'b1, 25'sd50, -25'sd50, -25'sd10, 25'sd10, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd6, -24'sd150, -24'sd60, -24'sd130, -24'sd70, 3'd3, 3'd2,
          20'sd80, 20'sd60}, 1'b0, '0},
      '{KEEP_WIN,
        '{6'd7, 24'sd90, 24'sd140, -24'sd20, 24'sd20, 3'd7, 3'd0,
          -20'sd40, 20'sd0}, 1'b0, '0},
      '{KEEP_WIN,
        '{6'd8, -24'sd20, 24'sd20, 24'sd90, 24'sd95, 3'd0, 3'd7,
          20'sd0, -20'sd30}, 1'b0, '0},
      // check mode passes copies unclipped
      '{3'd1,
        '{6'd9, 24'sd500, 24'sd600, -24'sd10, 24'sd10, 3'd0, 3'd0, 20'sd0, 20'sd0}, 1'b1,
        '{6'd9, 1'b0, 25'sd500, 25'sd600, -25'sd10, 25'sd10, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd10, -24'sd250, -24'sd200, -24'sd250, -24'sd200, 3'd4, 3'd4,
          20'sd100, 20'sd100}, 1'b0, '0},
      '{KEEP_WIN,
        '{6'd11, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 3'd7, 3'd7,
          20'sh7FFFF, 20'sh7FFFF}, 1'b0, '0},
      // display disabled gives one empty copy
      '{3'd2,
        '{6'd42, -24'sd5, 24'sd5, -24'sd5, 24'sd5, 3'd7, 3'd7, 20'sd3, 20'sd3}, 1'b1,
        '{6'd42, 1'b0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 3'd0, 3'd0, 1'b1}},
      '{KEEP_WIN,
        '{6'd0, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 3'd7, 3'd7,
          20'sh80000, 20'sh80000}, 1'b1,
        '{6'd0, 1'b0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 3'd0, 3'd0, 1'b1}},
      // full range window and inverted windows
      '{3'd3,
        '{6'd62, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 3'd7, 3'd7,
          20'sh7FFFF, 20'sh7FFFF}, 1'b0, '0},
      '{KEEP_WIN,
        '{6'd33, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 3'd7, 3'd7,
          20'sh80000, 20'sh80000}, 1'b0, '0},
      '{3'd4,
        '{6'd13, -24'sd10, 24'sd10, -24'sd10, 24'sd10, 3'd1, 3'd1,
          20'sd5, 20'sd5}, 1'b0, '0},
      '{3'd5,
        '{6'd14, -24'sd60, 24'sd60, -24'sd60, 24'sd60, 3'd2, 3'd2,
          20'sd30, -20'sd30}, 1'b0, '0}
   };

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid   = 1'b0;
   logic                  req_tready;
   // layer, base_left, base_right, base_bottom, base_top, extra_cols,
   // extra_rows, step_x, step_y, zero pad
   logic [REQ_DATA_W-1:0] req_tdata    = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready   = 1'b0;
   // out_layer, box_left, box_right, box_bottom, box_top, col_index, row_index
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // hit
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   box_copy_type expected_copies [$];
   window_type   cur_win = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0};
   bit           req_quiet = 1'b0;
   bit           rsp_quiet = 1'b0;
   int           rsp_hold = 0;
   int           rsp_stall = 0;
   int           near_cx = 0;
   int           near_cy = 0;
   int           mismatches = 0;
   int           boxes_sent = 0;
   int           copies_checked = 0;
   int           settings_applied = 0;
   int           cycle_count = 0;

   repeated_box_window_clipper dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d copies outstanding", $time, expected_copies.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // expand the box row by row, column by column, test and clip each copy
   function automatic void predict_copies(box_item_type it);
      int           l, r, b, t;
      int           wl, wr, wb, wt;
      box_copy_type c;
      wl = $signed(cur_win.left);
      wr = $signed(cur_win.right);
      wb = $signed(cur_win.bottom);
      wt = $signed(cur_win.top);
      c = '0;
      c.layer = it.layer;
      if (!cur_win.visible) begin
         c.last = 1'b1;
         expected_copies.push_back(c);
         return;
      end
      for (int row = 0; row <= int'(it.rows); row++) begin
         for (int col = 0; col <= int'(it.cols); col++) begin
            l = $signed(it.left) + col * $signed(it.step_x);
            r = $signed(it.right) + col * $signed(it.step_x);
            b = $signed(it.bottom) + row * $signed(it.step_y);
            t = $signed(it.top) + row * $signed(it.step_y);
            c.hit = (l < wr) && (r > wl) && (b < wt) && (t > wb);
            if (!cur_win.check) begin
               l = (l > wl) ? l : wl;
               r = (r < wr) ? r : wr;
               b = (b > wb) ? b : wb;
               t = (t < wt) ? t : wt;
            end
            c.left   = EDGE_W'(l);
            c.right  = EDGE_W'(r);
            c.bottom = EDGE_W'(b);
            c.top    = EDGE_W'(t);
            c.col    = COUNT_W'(col);
            c.row    = COUNT_W'(row);
            c.last   = (col == int'(it.cols)) && (row == int'(it.rows));
            expected_copies.push_back(c);
         end
      end
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   task automatic csr_write(rbwc_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_window(window_type w);
      req_tvalid <= 1'b0;
      while (expected_copies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(rbwc_pkg::CSR_WIN_LEFT,   {{8{w.left[COORD_W-1]}}, w.left});
      csr_write(rbwc_pkg::CSR_WIN_RIGHT,  {{8{w.right[COORD_W-1]}}, w.right});
      csr_write(rbwc_pkg::CSR_WIN_BOTTOM, {{8{w.bottom[COORD_W-1]}}, w.bottom});
      csr_write(rbwc_pkg::CSR_WIN_TOP,    {{8{w.top[COORD_W-1]}}, w.top});
      csr_write(rbwc_pkg::CSR_VISIBLE,    CSR_DATA_W'(w.visible));
      csr_write(rbwc_pkg::CSR_CHECK_MODE, CSR_DATA_W'(w.check));
      cur_win = w;
      settings_applied++;
   endtask

   task automatic send_box(box_item_type it, bit typed, box_copy_type golden);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({it.step_y, it.step_x, it.rows, it.cols, it.top,
                                 it.bottom, it.right, it.left, it.layer});
      do @(posedge clock); while (!req_tready);
      if (typed)
         expected_copies.push_back(golden);
      else
         predict_copies(it);
      boxes_sent++;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_hold   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         if (rsp_hold == 1)
            rsp_tready <= 1'b1;
      end else if (rsp_tvalid && rsp_tready && !rsp_quiet) begin
         rsp_stall = $urandom_range(0, MAX_IDLE);
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_stall;
         end
      end
   end

   always @(posedge clock) begin
      box_copy_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_copies.size() == 0) begin
            mismatches++;
            $display("%0t: copy expected none, actual layer %0d col %0d row %0d",
                     $time, rsp_tdata[5:0], rsp_tdata[108:106], rsp_tdata[111:109]);
         end else begin
            e = expected_copies.pop_front();
            check_field("out_layer", e.layer, rsp_tdata[5:0]);
            check_field("hit", e.hit, rsp_tuser);
            check_field("box_left", $signed(e.left), $signed(rsp_tdata[30:6]));
            check_field("box_right", $signed(e.right), $signed(rsp_tdata[55:31]));
            check_field("box_bottom", $signed(e.bottom), $signed(rsp_tdata[80:56]));
            check_field("box_top", $signed(e.top), $signed(rsp_tdata[105:81]));
            check_field("col_index", e.col, rsp_tdata[108:106]);
            check_field("row_index", e.row, rsp_tdata[111:109]);
            check_field("last", e.last, rsp_tlast);
            copies_checked++;
         end
      end
   end

   initial begin : stimulus
      window_type   w;
      box_item_type it;
      int           hw, hh;
      bit           wide;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].win_sel != KEEP_WIN)
            apply_window(DIR_WINDOWS[DIRECTED_ROWS[i].win_sel]);
         send_box(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].golden);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         wide = ($urandom_range(0, 3) == 0);
         if (wide) begin
            w.left   = COORD_W'($urandom);
            w.right  = COORD_W'($urandom);
            w.bottom = COORD_W'($urandom);
            w.top    = COORD_W'($urandom);
         end else begin
            near_cx  = int'($urandom_range(0, 8000000)) - 4000000;
            near_cy  = int'($urandom_range(0, 8000000)) - 4000000;
            hw       = $urandom_range(0, 3000);
            hh       = $urandom_range(0, 3000);
            w.left   = COORD_W'(near_cx - hw);
            w.right  = COORD_W'(near_cx + hw);
            w.bottom = COORD_W'(near_cy - hh);
            w.top    = COORD_W'(near_cy + hh);
         end
         w.visible = (p == 3) ? 1'b0 : ($urandom_range(0, 7) != 0);
         w.check   = $urandom_range(0, 1);
         apply_window(w);
         req_quiet = (p % 3 == 1);
         rsp_quiet = (p % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it.layer = LAYER_W'($urandom);
            it.cols  = COUNT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                           : $urandom_range(0, 7));
            it.rows  = COUNT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                           : $urandom_range(0, 7));
            if (!wide && $urandom_range(0, 99) < 85) begin
               it.left   = COORD_W'(near_cx + int'($urandom_range(0, 10000)) - 5000);
               it.right  = COORD_W'($signed(it.left) + int'($urandom_range(0, 4200)) - 200);
               it.bottom = COORD_W'(near_cy + int'($urandom_range(0, 10000)) - 5000);
               it.top    = COORD_W'($signed(it.bottom) + int'($urandom_range(0, 4200)) - 200);
               it.step_x = STEP_W'(int'($urandom_range(0, 4000)) - 2000);
               it.step_y = STEP_W'(int'($urandom_range(0, 4000)) - 2000);
            end else begin
               it.left   = COORD_W'($urandom);
               it.right  = COORD_W'($urandom);
               it.bottom = COORD_W'($urandom);
               it.top    = COORD_W'($urandom);
               it.step_x = STEP_W'($urandom);
               it.step_y = STEP_W'($urandom);
            end
            send_box(it, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_copies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d boxes under %0d window settings", boxes_sent,
               settings_applied + 1);
      $display("%0d copies compared, %0d field mismatches", copies_checked, mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
